[sv/rrg_pkg.sv]
// Shared types, widths and codes for the refresh rate governor.
package rrg_pkg;

    localparam int MODE_SLOTS_DEF = 16;

    localparam int RATE_W     = 10;
    localparam int CONF_W     = 8;
    localparam int MS_W       = 16;
    localparam int COUNT_W    = 5;
    localparam int SLOT_W     = 4;
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int BEST_W     = 5;

    localparam logic [RATE_W:0]   RATE_NONE   = '1;
    localparam logic [CONF_W:0]   CONF_NONE   = '1;
    localparam logic [BEST_W-1:0] CLOSE_LIMIT = BEST_W'(30);

    localparam logic [MODE_W-1:0] MODE_EVAL  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INVAL = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_EXACT = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CLOSE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSCREEN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PHYS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEF_IDLE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PHYS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PS_MAX     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SLACK      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MODE_COUNT = 3'd6;

    localparam logic [RATE_W-1:0] DEF_IDLE_RESET = RATE_W'(60);
    localparam logic [RATE_W-1:0] PS_MAX_RESET   = RATE_W'(60);

    typedef struct packed {
        logic [RATE_W-1:0]  offscreen_rate;
        logic [RATE_W-1:0]  min_physical_rate;
        logic [RATE_W-1:0]  default_idle_rate;
        logic [RATE_W-1:0]  max_physical_rate;
        logic [RATE_W-1:0]  power_save_max_rate;
        logic [MS_W-1:0]    touch_slack_ms;
        logic [COUNT_W-1:0] mode_count;
    } cfg_regs_t;

    typedef struct packed {
        logic              equal;
        logic              closer;
        logic [RATE_W-1:0] diff;
    } dist_res_t;

endpackage

[sv/rrg_target_sel.sv]
// Target rate selection, panel clamp and repeat suppression.
module rrg_target_sel
    import rrg_pkg::*;
(
    input  cfg_regs_t         cfg,
    input  logic              screen_on,
    input  logic              brightness_clamp,
    input  logic              touching,
    input  logic [MS_W-1:0]   ms_since_touch,
    input  logic              power_save,
    input  logic [RATE_W-1:0] idle_rate,
    input  logic [RATE_W-1:0] engaged_rate,
    input  logic [RATE_W:0]   last_set_rate,
    output logic [RATE_W-1:0] target,
    output logic              go
);

    logic [RATE_W-1:0] raw;
    logic              drop_raw;

    always_comb
    begin
        if (!screen_on)
        begin
            raw = cfg.offscreen_rate;
        end
        else if (brightness_clamp)
        begin
            raw = (cfg.min_physical_rate != '0) ? cfg.min_physical_rate
                                                : cfg.default_idle_rate;
        end
        else if (touching || (ms_since_touch < cfg.touch_slack_ms))
        begin
            raw = (power_save && (engaged_rate > cfg.power_save_max_rate))
                ? cfg.power_save_max_rate : engaged_rate;
        end
        else
        begin
            raw = idle_rate;
        end
        drop_raw = (raw == '0) || ({1'b0, raw} == last_set_rate);
        target = ((cfg.max_physical_rate != '0) && (raw > cfg.max_physical_rate))
               ? cfg.max_physical_rate : raw;
        go = !drop_raw && ({1'b0, target} != last_set_rate);
    end

endmodule

[sv/rrg_dist_unit.sv]
// Shared distance unit: absolute rate difference and compare against best.
module rrg_dist_unit
    import rrg_pkg::*;
(
    input  logic [RATE_W-1:0] entry_rate,
    input  logic [RATE_W-1:0] want_rate,
    input  logic [BEST_W-1:0] best,
    output dist_res_t         res
);

    always_comb
    begin
        res.diff   = (entry_rate > want_rate) ? (entry_rate - want_rate)
                                              : (want_rate - entry_rate);
        res.equal  = (entry_rate == want_rate);
        res.closer = (res.diff < {{(RATE_W-BEST_W){1'b0}}, best});
    end

endmodule

[sv/rrg_mode_table.sv]
// Mode table memory: one write port, one registered read port.
module rrg_mode_table
    import rrg_pkg::*;
#(
    parameter int SLOTS = MODE_SLOTS_DEF,
    parameter int AW    = 4
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [RATE_W-1:0] wrate,
    input  logic [CONF_W-1:0] wconf,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [RATE_W-1:0] rrate,
    output logic [CONF_W-1:0] rconf
);

    logic [RATE_W+CONF_W-1:0] mem [SLOTS];
    logic [RATE_W+CONF_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wrate, wconf};
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rrate = rdata_reg[RATE_W+CONF_W-1:CONF_W];
    assign rconf = rdata_reg[CONF_W-1:0];

endmodule

[sv/refresh_rate_governor.sv]
// Refresh rate governor top level: config registers, cache and lookup sequencer.
//
//  channel   handshake            payload
//  item      start / busy         mode .. entry_config
//  result    result_valid strobe  status, applied_rate, config_id
//  config    cfg_we               cfg_index, cfg_data
//
// Table writes, invalidates, suppressed evaluations and cache hits leave busy
// low; a cache hit shows its result in the cycle after start.
// A cache miss walks the mode table through the single read port and the
// shared distance unit, reading n = min(mode_count, MODE_SLOTS) entries;
// the result is shown in the same cycle that busy falls.
// Reset clears the cache and last rate; the table is undefined until written.
// The receiver cannot stall results.
module refresh_rate_governor
    import rrg_pkg::*;
#(
    parameter int MODE_SLOTS = MODE_SLOTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [MODE_W-1:0]     mode,
    input  logic                  screen_on,
    input  logic                  brightness_clamp,
    input  logic                  touching,
    input  logic [MS_W-1:0]       ms_since_touch,
    input  logic                  power_save,
    input  logic [RATE_W-1:0]     idle_rate,
    input  logic [RATE_W-1:0]     engaged_rate,
    input  logic [SLOT_W-1:0]     entry_index,
    input  logic [RATE_W-1:0]     entry_rate,
    input  logic [CONF_W-1:0]     entry_config,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  result_valid,
    output logic [STATUS_W-1:0]   status,
    output logic [RATE_W-1:0]     applied_rate,
    output logic [CONF_W-1:0]     config_id
);

    localparam int AW = (MODE_SLOTS > 1) ? $clog2(MODE_SLOTS) : 1;
    localparam int CW = $clog2(MODE_SLOTS + 1);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t              state_reg, state_next;
    cfg_regs_t           cfg_reg, cfg_next;
    logic [RATE_W:0]     last_reg, last_next;
    logic [RATE_W:0]     cached_rate_reg, cached_rate_next;
    logic [CONF_W:0]     cached_conf_reg, cached_conf_next;
    logic [STATUS_W-1:0] cached_status_reg, cached_status_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic                pend_reg, pend_next;
    logic [RATE_W-1:0]   rate_reg, rate_next;
    logic [BEST_W-1:0]   best_reg, best_next;
    logic                exact_reg, exact_next;
    logic [CONF_W-1:0]   exact_conf_reg, exact_conf_next;
    logic                close_reg, close_next;
    logic [CONF_W-1:0]   close_conf_reg, close_conf_next;
    logic                valid_reg, valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [RATE_W-1:0]   applied_reg, applied_next;
    logic [CONF_W-1:0]   conf_id_reg, conf_id_next;

    logic                accept;
    logic [RATE_W-1:0]   target;
    logic                target_go;
    logic [31:0]         count_wide;
    logic [CW-1:0]       n_lim;
    logic                rd_en;
    logic [31:0]         slot_wide;
    logic                tbl_we;
    logic [RATE_W-1:0]   rd_rate;
    logic [CONF_W-1:0]   rd_conf;
    dist_res_t           cmp_res;
    logic [STATUS_W-1:0] fin_status;
    logic [CONF_W:0]     fin_conf;

    assign accept     = start && (state_reg == ST_IDLE);
    assign count_wide = 32'(cfg_reg.mode_count);
    assign n_lim      = (count_wide > 32'(MODE_SLOTS)) ? CW'(MODE_SLOTS) : CW'(count_wide);
    assign rd_en      = (state_reg == ST_SCAN) && (idx_reg < n_lim);
    assign slot_wide  = 32'(entry_index);
    assign tbl_we     = accept && (mode == MODE_WRITE) && (slot_wide < 32'(MODE_SLOTS));

    rrg_target_sel u_target (
        .cfg              (cfg_reg),
        .screen_on        (screen_on),
        .brightness_clamp (brightness_clamp),
        .touching         (touching),
        .ms_since_touch   (ms_since_touch),
        .power_save       (power_save),
        .idle_rate        (idle_rate),
        .engaged_rate     (engaged_rate),
        .last_set_rate    (last_reg),
        .target           (target),
        .go               (target_go)
    );

    rrg_mode_table #(
        .SLOTS (MODE_SLOTS),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (slot_wide[AW-1:0]),
        .wrate (entry_rate),
        .wconf (entry_config),
        .re    (rd_en),
        .raddr (idx_reg[AW-1:0]),
        .rrate (rd_rate),
        .rconf (rd_conf)
    );

    rrg_dist_unit u_dist (
        .entry_rate (rd_rate),
        .want_rate  (rate_reg),
        .best       (best_reg),
        .res        (cmp_res)
    );

    always_comb
    begin
        if (exact_reg)
        begin
            fin_status = STATUS_EXACT;
            fin_conf   = {1'b0, exact_conf_reg};
        end
        else if (close_reg)
        begin
            fin_status = STATUS_CLOSE;
            fin_conf   = {1'b0, close_conf_reg};
        end
        else
        begin
            fin_status = STATUS_NONE;
            fin_conf   = CONF_NONE;
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        cfg_next           = cfg_reg;
        last_next          = last_reg;
        cached_rate_next   = cached_rate_reg;
        cached_conf_next   = cached_conf_reg;
        cached_status_next = cached_status_reg;
        idx_next           = idx_reg;
        pend_next          = rd_en;
        rate_next          = rate_reg;
        best_next          = best_reg;
        exact_next         = exact_reg;
        exact_conf_next    = exact_conf_reg;
        close_next         = close_reg;
        close_conf_next    = close_conf_reg;
        valid_next         = 1'b0;
        status_next        = status_reg;
        applied_next       = applied_reg;
        conf_id_next       = conf_id_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_OFFSCREEN:  cfg_next.offscreen_rate      = cfg_data[RATE_W-1:0];
                REG_MIN_PHYS:   cfg_next.min_physical_rate   = cfg_data[RATE_W-1:0];
                REG_DEF_IDLE:   cfg_next.default_idle_rate   = cfg_data[RATE_W-1:0];
                REG_MAX_PHYS:   cfg_next.max_physical_rate   = cfg_data[RATE_W-1:0];
                REG_PS_MAX:     cfg_next.power_save_max_rate = cfg_data[RATE_W-1:0];
                REG_SLACK:      cfg_next.touch_slack_ms      = cfg_data[MS_W-1:0];
                REG_MODE_COUNT: cfg_next.mode_count          = cfg_data[COUNT_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (mode == MODE_EVAL) && target_go)
                begin
                    if ({1'b0, target} == cached_rate_reg)
                    begin
                        valid_next   = 1'b1;
                        status_next  = cached_status_reg;
                        applied_next = target;
                        conf_id_next = (cached_status_reg == STATUS_NONE)
                                     ? '0 : cached_conf_reg[CONF_W-1:0];
                        if (cached_status_reg != STATUS_NONE)
                        begin
                            last_next = {1'b0, target};
                        end
                    end
                    else
                    begin
                        rate_next  = target;
                        idx_next   = '0;
                        best_next  = CLOSE_LIMIT;
                        exact_next = 1'b0;
                        close_next = 1'b0;
                        state_next = ST_SCAN;
                    end
                end
                else if (accept && (mode == MODE_INVAL))
                begin
                    cached_rate_next   = RATE_NONE;
                    cached_conf_next   = CONF_NONE;
                    cached_status_next = STATUS_NONE;
                    last_next          = RATE_NONE;
                end
            end
            ST_SCAN:
            begin
                if (pend_reg)
                begin
                    if (cmp_res.equal && !exact_reg)
                    begin
                        exact_next      = 1'b1;
                        exact_conf_next = rd_conf;
                    end
                    if (cmp_res.closer)
                    begin
                        best_next       = cmp_res.diff[BEST_W-1:0];
                        close_next      = 1'b1;
                        close_conf_next = rd_conf;
                    end
                end
                if (rd_en)
                begin
                    idx_next = idx_reg + CW'(1);
                end
                else if (!pend_reg)
                begin
                    valid_next         = 1'b1;
                    status_next        = fin_status;
                    applied_next       = rate_reg;
                    conf_id_next       = (fin_status == STATUS_NONE) ? '0 : fin_conf[CONF_W-1:0];
                    cached_rate_next   = {1'b0, rate_reg};
                    cached_conf_next   = fin_conf;
                    cached_status_next = fin_status;
                    if (fin_status != STATUS_NONE)
                    begin
                        last_next = {1'b0, rate_reg};
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg                     <= ST_IDLE;
            cfg_reg.offscreen_rate        <= '0;
            cfg_reg.min_physical_rate     <= '0;
            cfg_reg.default_idle_rate     <= DEF_IDLE_RESET;
            cfg_reg.max_physical_rate     <= '0;
            cfg_reg.power_save_max_rate   <= PS_MAX_RESET;
            cfg_reg.touch_slack_ms        <= '0;
            cfg_reg.mode_count            <= '0;
            last_reg                      <= RATE_NONE;
            cached_rate_reg               <= RATE_NONE;
            cached_conf_reg               <= CONF_NONE;
            cached_status_reg             <= STATUS_NONE;
            pend_reg                      <= 1'b0;
            valid_reg                     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            cfg_reg           <= cfg_next;
            last_reg          <= last_next;
            cached_rate_reg   <= cached_rate_next;
            cached_conf_reg   <= cached_conf_next;
            cached_status_reg <= cached_status_next;
            pend_reg          <= pend_next;
            valid_reg         <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        rate_reg       <= rate_next;
        best_reg       <= best_next;
        exact_reg      <= exact_next;
        exact_conf_reg <= exact_conf_next;
        close_reg      <= close_next;
        close_conf_reg <= close_conf_next;
        status_reg     <= status_next;
        applied_reg    <= applied_next;
        conf_id_reg    <= conf_id_next;
    end

    assign busy         = (state_reg == ST_SCAN);
    assign result_valid = valid_reg;
    assign status       = status_reg;
    assign applied_rate = applied_reg;
    assign config_id    = conf_id_reg;

`ifndef SYNTH
    a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !result_valid)
        else $error("result strobe during table walk");

    a_none_has_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status == STATUS_NONE)) |-> (config_id == '0))
        else $error("unmapped result carries a config id");

    a_last_tracks_result: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status != STATUS_NONE)) |-> (last_reg == {1'b0, applied_rate}))
        else $error("last set rate does not follow mapped result");

    a_read_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == ST_SCAN))
        else $error("table read pending outside walk");
`endif

endmodule

[test/tb_refresh_rate_governor.sv]
// Testbench for refresh_rate_governor: directed and random transactions, predicted results.
module tb_refresh_rate_governor;
    timeunit 1ns;
    timeprecision 1ps;

    import rrg_pkg::*;

    localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 3'd7;
    localparam int SETTLE          = 4;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int DRAIN_CYCLES    = MODE_SLOTS_DEF + 8;
    localparam int TIMEOUT_NS      = 12_000_000;

    typedef enum logic [1:0] {ACT_ITEM, ACT_REG, ACT_DRAIN} act_kind_t;

    typedef struct packed {
        act_kind_t             kind;
        logic [7:0]            gap;
        logic [MODE_W-1:0]     mode;
        logic                  screen_on;
        logic                  brightness_clamp;
        logic                  touching;
        logic [MS_W-1:0]       ms_since_touch;
        logic                  power_save;
        logic [RATE_W-1:0]     idle_rate;
        logic [RATE_W-1:0]     engaged_rate;
        logic [SLOT_W-1:0]     entry_index;
        logic [RATE_W-1:0]     entry_rate;
        logic [CONF_W-1:0]     entry_config;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_data;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [RATE_W-1:0]   rate;
        logic [CONF_W-1:0]   conf;
    } rate_pick_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [MODE_W-1:0]     mode = '0;
    logic                  screen_on = 1'b0;
    logic                  brightness_clamp = 1'b0;
    logic                  touching = 1'b0;
    logic [MS_W-1:0]       ms_since_touch = '0;
    logic                  power_save = 1'b0;
    logic [RATE_W-1:0]     idle_rate = '0;
    logic [RATE_W-1:0]     engaged_rate = '0;
    logic [SLOT_W-1:0]     entry_index = '0;
    logic [RATE_W-1:0]     entry_rate = '0;
    logic [CONF_W-1:0]     entry_config = '0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  result_valid;
    logic [STATUS_W-1:0]   status;
    logic [RATE_W-1:0]     applied_rate;
    logic [CONF_W-1:0]     config_id;

    refresh_rate_governor u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .mode             (mode),
        .screen_on        (screen_on),
        .brightness_clamp (brightness_clamp),
        .touching         (touching),
        .ms_since_touch   (ms_since_touch),
        .power_save       (power_save),
        .idle_rate        (idle_rate),
        .engaged_rate     (engaged_rate),
        .entry_index      (entry_index),
        .entry_rate       (entry_rate),
        .entry_config     (entry_config),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .result_valid     (result_valid),
        .status           (status),
        .applied_rate     (applied_rate),
        .config_id        (config_id)
    );

    request_t   request_q[$];
    rate_pick_t pending_picks[$];
    int         error_total = 0;

    // governor model state
    cfg_regs_t           shadow;
    logic [RATE_W:0]     last_rate;
    logic [RATE_W:0]     memo_rate;
    logic [CONF_W:0]     memo_conf;
    logic [STATUS_W-1:0] memo_status;
    logic [RATE_W-1:0]   slot_rate [MODE_SLOTS_DEF];
    logic [CONF_W-1:0]   slot_conf [MODE_SLOTS_DEF];

    // stimulus generator state
    logic [RATE_W-1:0]   gen_rates [MODE_SLOTS_DEF];
    logic [RATE_W-1:0]   gen_prev_rate = '0;
    logic [MS_W-1:0]     gen_slack = '0;
    bit                  gen_calm = 1'b0;

    // driver state
    request_t   head;
    request_t   in_flight;
    bit         launch;
    bit         write_reg;
    bit         gap_loaded = 1'b0;
    int         gap_left = 0;
    int         quiet_cycles = 0;
    rate_pick_t seen_pick;
    rate_pick_t want_pick;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic flag_error(input string what);
        if (error_total < 50)
            $display("%0t ERROR %s", $time, what);
        error_total++;
    endtask

    task automatic latch_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_OFFSCREEN:  shadow.offscreen_rate = data[RATE_W-1:0];
            REG_MIN_PHYS:   shadow.min_physical_rate = data[RATE_W-1:0];
            REG_DEF_IDLE:   shadow.default_idle_rate = data[RATE_W-1:0];
            REG_MAX_PHYS:   shadow.max_physical_rate = data[RATE_W-1:0];
            REG_PS_MAX:     shadow.power_save_max_rate = data[RATE_W-1:0];
            REG_SLACK:      shadow.touch_slack_ms = data[MS_W-1:0];
            REG_MODE_COUNT: shadow.mode_count = data[COUNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic predict_rate_pick(input request_t rq);
        logic [RATE_W-1:0] target;
        rate_pick_t        pick;
        int                n;
        int                best;
        int                d;
        bit                hit;
        if (rq.mode == MODE_WRITE)
        begin
            slot_rate[rq.entry_index] = rq.entry_rate;
            slot_conf[rq.entry_index] = rq.entry_config;
            return;
        end
        if (rq.mode == MODE_INVAL)
        begin
            memo_rate = RATE_NONE;
            memo_conf = CONF_NONE;
            memo_status = STATUS_NONE;
            last_rate = RATE_NONE;
            return;
        end
        if (rq.mode != MODE_EVAL)
            return;

        if (!rq.screen_on)
            target = shadow.offscreen_rate;
        else if (rq.brightness_clamp)
            target = (shadow.min_physical_rate != '0) ? shadow.min_physical_rate
                                                      : shadow.default_idle_rate;
        else if (rq.touching || rq.ms_since_touch < shadow.touch_slack_ms)
        begin
            target = rq.engaged_rate;
            if (rq.power_save && target > shadow.power_save_max_rate)
                target = shadow.power_save_max_rate;
        end
        else
            target = rq.idle_rate;

        if (target == '0 || {1'b0, target} == last_rate)
            return;
        if (shadow.max_physical_rate != '0 && target > shadow.max_physical_rate)
            target = shadow.max_physical_rate;
        if ({1'b0, target} == last_rate)
            return;

        if ({1'b0, target} != memo_rate)
        begin
            memo_rate = {1'b0, target};
            memo_status = STATUS_NONE;
            memo_conf = CONF_NONE;
            n = (shadow.mode_count > COUNT_W'(MODE_SLOTS_DEF)) ? MODE_SLOTS_DEF
                                                                : int'(shadow.mode_count);
            hit = 1'b0;
            for (int i = 0; i < n; i++)
            begin
                if (!hit && slot_rate[i] == target)
                begin
                    hit = 1'b1;
                    memo_status = STATUS_EXACT;
                    memo_conf = {1'b0, slot_conf[i]};
                end
            end
            if (!hit)
            begin
                best = int'(CLOSE_LIMIT);
                for (int i = 0; i < n; i++)
                begin
                    d = int'(slot_rate[i]) - int'(target);
                    if (d < 0)
                        d = -d;
                    if (d < best)
                    begin
                        best = d;
                        memo_status = STATUS_CLOSE;
                        memo_conf = {1'b0, slot_conf[i]};
                    end
                end
            end
        end

        pick.status = memo_status;
        pick.rate = target;
        pick.conf = (memo_status == STATUS_NONE) ? '0 : memo_conf[CONF_W-1:0];
        if (memo_status != STATUS_NONE)
            last_rate = {1'b0, target};
        pending_picks.push_back(pick);
    endtask

    function automatic logic [7:0] pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (gen_calm || r < 50)
            return 8'd0;
        if (r < 85)
            return 8'($urandom_range(1, 3));
        if (r < 97)
            return 8'($urandom_range(4, 12));
        return 8'($urandom_range(20, 60));
    endfunction

    function automatic logic [RATE_W-1:0] pick_rate();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 30)
            v = int'(gen_rates[$urandom_range(0, MODE_SLOTS_DEF - 1)]);
        else if (r < 55)
            v = int'(gen_rates[$urandom_range(0, MODE_SLOTS_DEF - 1)])
                + int'($urandom_range(0, 70)) - 35;
        else if (r < 70)
            v = int'(gen_prev_rate);
        else if (r < 80)
        begin
            case ($urandom_range(0, 2))
                0: v = 0;
                1: v = 1;
                default: v = 1023;
            endcase
        end
        else
            v = int'($urandom_range(0, 1023));
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        gen_prev_rate = RATE_W'(v);
        return RATE_W'(v);
    endfunction

    function automatic logic [MS_W-1:0] pick_ms();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 25)
            v = 0;
        else if (r < 38)
            v = 65535;
        else if (r < 65)
            v = int'(gen_slack) + int'($urandom_range(0, 6)) - 3;
        else
            v = int'($urandom_range(0, 65535));
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return MS_W'(v);
    endfunction

    function automatic request_t noise_req();
        request_t rq;
        rq.kind = ACT_ITEM;
        rq.gap = pick_gap();
        rq.mode = MODE_UNUSED;
        rq.screen_on = 1'($urandom);
        rq.brightness_clamp = 1'($urandom);
        rq.touching = 1'($urandom);
        rq.ms_since_touch = MS_W'($urandom);
        rq.power_save = 1'($urandom);
        rq.idle_rate = RATE_W'($urandom);
        rq.engaged_rate = RATE_W'($urandom);
        rq.entry_index = SLOT_W'($urandom);
        rq.entry_rate = RATE_W'($urandom);
        rq.entry_config = CONF_W'($urandom);
        rq.reg_index = '0;
        rq.reg_data = '0;
        return rq;
    endfunction

    function automatic request_t eval_req(input logic scr, input logic clamp, input logic tch,
                                          input logic [MS_W-1:0] ms, input logic ps,
                                          input logic [RATE_W-1:0] idle,
                                          input logic [RATE_W-1:0] engaged);
        request_t rq;
        rq = noise_req();
        rq.mode = MODE_EVAL;
        rq.screen_on = scr;
        rq.brightness_clamp = clamp;
        rq.touching = tch;
        rq.ms_since_touch = ms;
        rq.power_save = ps;
        rq.idle_rate = idle;
        rq.engaged_rate = engaged;
        return rq;
    endfunction

    function automatic request_t table_req(input logic [SLOT_W-1:0] idx,
                                           input logic [RATE_W-1:0] rate,
                                           input logic [CONF_W-1:0] conf);
        request_t rq;
        rq = noise_req();
        rq.mode = MODE_WRITE;
        rq.entry_index = idx;
        rq.entry_rate = rate;
        rq.entry_config = conf;
        gen_rates[idx] = rate;
        return rq;
    endfunction

    function automatic request_t inval_req();
        request_t rq;
        rq = noise_req();
        rq.mode = MODE_INVAL;
        return rq;
    endfunction

    function automatic request_t reg_req(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] value);
        request_t              rq;
        logic [CFG_DATA_W-1:0] mask;
        rq = noise_req();
        rq.kind = ACT_REG;
        rq.gap = '0;
        case (idx)
            REG_SLACK:      mask = 16'hFFFF;
            REG_MODE_COUNT: mask = 16'h001F;
            REG_SPARE:      mask = 16'h0000;
            default:        mask = 16'h03FF;
        endcase
        rq.reg_index = idx;
        rq.reg_data = (CFG_DATA_W'($urandom) & ~mask) | (value & mask);
        if (idx == REG_SLACK)
            gen_slack = value;
        return rq;
    endfunction

    function automatic request_t drain_req();
        request_t rq;
        rq = noise_req();
        rq.kind = ACT_DRAIN;
        rq.gap = '0;
        return rq;
    endfunction

    // driver: one queued request per free cycle once its gap has run out, registers only when the block is quiet
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            mode <= '0;
            screen_on <= 1'b0;
            brightness_clamp <= 1'b0;
            touching <= 1'b0;
            ms_since_touch <= '0;
            power_save <= 1'b0;
            idle_rate <= '0;
            engaged_rate <= '0;
            entry_index <= '0;
            entry_rate <= '0;
            entry_config <= '0;
            cfg_we <= 1'b0;
            cfg_index <= '0;
            cfg_data <= '0;
            shadow.offscreen_rate = '0;
            shadow.min_physical_rate = '0;
            shadow.default_idle_rate = DEF_IDLE_RESET;
            shadow.max_physical_rate = '0;
            shadow.power_save_max_rate = PS_MAX_RESET;
            shadow.touch_slack_ms = '0;
            shadow.mode_count = '0;
            last_rate = RATE_NONE;
            memo_rate = RATE_NONE;
            memo_conf = CONF_NONE;
            memo_status = STATUS_NONE;
            quiet_cycles = 0;
        end
        else
        begin
            launch = 1'b0;
            write_reg = 1'b0;
            if (start && !busy)
                predict_rate_pick(in_flight);
            if (start || busy || pending_picks.size() != 0)
                quiet_cycles = 0;
            else
                quiet_cycles++;

            if (!(start && busy) && request_q.size() != 0)
            begin
                if (!gap_loaded)
                begin
                    gap_left = int'(request_q[0].gap);
                    gap_loaded = 1'b1;
                end
                if (gap_left != 0)
                    gap_left--;
                else
                begin
                    head = request_q[0];
                    if (head.kind == ACT_ITEM)
                    begin
                        launch = 1'b1;
                        in_flight = head;
                        mode <= head.mode;
                        screen_on <= head.screen_on;
                        brightness_clamp <= head.brightness_clamp;
                        touching <= head.touching;
                        ms_since_touch <= head.ms_since_touch;
                        power_save <= head.power_save;
                        idle_rate <= head.idle_rate;
                        engaged_rate <= head.engaged_rate;
                        entry_index <= head.entry_index;
                        entry_rate <= head.entry_rate;
                        entry_config <= head.entry_config;
                    end
                    else if (head.kind == ACT_REG && quiet_cycles >= SETTLE)
                    begin
                        write_reg = 1'b1;
                        latch_register(head.reg_index, head.reg_data);
                        cfg_index <= head.reg_index;
                        cfg_data <= head.reg_data;
                    end
                    if (launch || write_reg || (head.kind == ACT_DRAIN && quiet_cycles >= SETTLE))
                    begin
                        void'(request_q.pop_front());
                        gap_loaded = 1'b0;
                    end
                end
            end
            if (!(start && busy))
                start <= launch;
            cfg_we <= write_reg;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && $isunknown(result_valid))
            flag_error("result_valid is unknown");
        else if (rst_n && result_valid)
        begin
            seen_pick.status = status;
            seen_pick.rate = applied_rate;
            seen_pick.conf = config_id;
            if (pending_picks.size() == 0)
                flag_error($sformatf("unexpected transaction status=%0d rate=%0d conf=%0d",
                                     status, applied_rate, config_id));
            else
            begin
                want_pick = pending_picks.pop_front();
                if (seen_pick.status !== want_pick.status)
                    flag_error($sformatf("status %0d, expected %0d (rate %0d)",
                                         seen_pick.status, want_pick.status, want_pick.rate));
                if (seen_pick.rate !== want_pick.rate)
                    flag_error($sformatf("applied_rate %0d, expected %0d",
                                         seen_pick.rate, want_pick.rate));
                if (seen_pick.conf !== want_pick.conf)
                    flag_error($sformatf("config_id %0d, expected %0d (rate %0d)",
                                         seen_pick.conf, want_pick.conf, want_pick.rate));
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("tb_refresh_rate_governor NOT OK");
        $finish;
    end

    initial
    begin
        int                    done;
        int                    r;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] value;

        for (int i = 0; i < MODE_SLOTS_DEF; i++)
        begin
            gen_rates[i] = '0;
            slot_rate[i] = '0;
            slot_conf[i] = '0;
        end

        // directed: reset configuration, empty table
        request_q.push_back(eval_req(1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 10'd0, 10'd0));
        request_q.push_back(eval_req(1'b1, 1'b1, 1'b0, 16'd0, 1'b0, 10'd0, 10'd0));
        request_q.push_back(eval_req(1'b1, 1'b1, 1'b1, 16'hFFFF, 1'b1, 10'd1023, 10'd1023));
        request_q.push_back(noise_req());
        request_q.push_back(table_req(4'd0, 10'd60, 8'h11));
        request_q.push_back(table_req(4'd1, 10'd90, 8'h22));
        request_q.push_back(table_req(4'd2, 10'd120, 8'h33));
        request_q.push_back(table_req(4'd3, 10'd1023, 8'hFF));
        request_q.push_back(table_req(4'd4, 10'd0, 8'h00));
        request_q.push_back(table_req(4'd5, 10'd144, 8'h80));
        request_q.push_back(reg_req(REG_MODE_COUNT, 16'd6));
        // exact, repeated rate, tie between two closest entries, top rate, power-save cap
        request_q.push_back(eval_req(1'b1, 1'b0, 1'b1, 16'd0, 1'b0, 10'd0, 10'd90));
        request_q.push_back(eval_req(1'b1, 1'b0, 1'b1, 16'd0, 1'b0, 10'd0, 10'd90));
        request_q.push_back(eval_req(1'b1, 1'b0, 1'b0, 16'hFFFF, 1'b0, 10'd105, 10'd90));
        request_q.push_back(eval_req(1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 10'd1023, 10'd0));
        request_q.push_back(eval_req(1'b1, 1'b0, 1'b1, 16'd0, 1'b1, 10'd5, 10'd1023));
        // no mapping, then stale cache after the table changes, then invalidate
        request_q.push_back(eval_req(1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 10'd500, 10'd0));
        request_q.push_back(table_req(4'd2, 10'd500, 8'h55));
        request_q.push_back(eval_req(1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 10'd500, 10'd0));
        request_q.push_back(inval_req());
        request_q.push_back(eval_req(1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 10'd500, 10'd0));
        // panel clamp, slack window, clamp landing on the last-set rate
        request_q.push_back(reg_req(REG_MAX_PHYS, 16'd100));
        request_q.push_back(reg_req(REG_SLACK, 16'hFFFF));
        request_q.push_back(eval_req(1'b1, 1'b0, 1'b0, 16'hFFFE, 1'b0, 10'd7, 10'd1023));
        request_q.push_back(reg_req(REG_MIN_PHYS, 16'd1023));
        request_q.push_back(eval_req(1'b1, 1'b1, 1'b0, 16'd0, 1'b0, 10'd7, 10'd7));

        // fill every slot so any mode_count is legal from here on
        for (int i = 0; i < MODE_SLOTS_DEF; i++)
            request_q.push_back(table_req(SLOT_W'(i), RATE_W'($urandom), CONF_W'($urandom)));

        for (int phase = 0; phase < PHASES; phase++)
        begin
            gen_calm = (phase % 4 == 2);
            for (int k = 0; k <= int'(REG_SPARE); k++)
            begin
                idx = CFG_IDX_W'(k);
                if (phase == 0)
                    value = 16'hFFFF;
                else if (phase == 1)
                    value = 16'd0;
                else
                begin
                    case ($urandom_range(0, 3))
                        0: value = 16'd0;
                        1: value = 16'hFFFF;
                        default: value = (idx == REG_MODE_COUNT) ? 16'($urandom_range(1, 16))
                                                                 : 16'($urandom);
                    endcase
                end
                request_q.push_back(reg_req(idx, value));
            end

            done = 0;
            while (done < ITEMS_PER_PHASE)
            begin
                r = $urandom_range(0, 99);
                if (r < 76)
                begin
                    request_q.push_back(eval_req($urandom_range(0, 99) < 92,
                                                 $urandom_range(0, 99) < 8,
                                                 $urandom_range(0, 99) < 35,
                                                 pick_ms(),
                                                 $urandom_range(0, 99) < 30,
                                                 pick_rate(), pick_rate()));
                    done++;
                end
                else if (r < 88)
                begin
                    request_q.push_back(table_req(SLOT_W'($urandom),
                                                  $urandom_range(0, 1) ? pick_rate()
                                                                       : RATE_W'($urandom),
                                                  CONF_W'($urandom)));
                    done++;
                end
                else if (r < 95)
                begin
                    request_q.push_back(inval_req());
                    done++;
                end
                else if (r < 98)
                    request_q.push_back(noise_req());
                else
                    request_q.push_back(drain_req());
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (request_q.size() != 0 || start)
            @(posedge clk);
        while (pending_picks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_total == 0)
            $display("tb_refresh_rate_governor OK");
        else
            $display("tb_refresh_rate_governor NOT OK");
        $finish;
    end

endmodule

[sim.f]
sv/rrg_pkg.sv
sv/rrg_target_sel.sv
sv/rrg_dist_unit.sv
sv/rrg_mode_table.sv
sv/refresh_rate_governor.sv
test/tb_refresh_rate_governor.sv
